[hdl/assert_macros.svh]
// Assertion macros shared by the parser RTL.
// Self-contained; included by every module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define WHP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define WHP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WHP_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define WHP_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hdl/whp_pkg.sv]
// Shared constants and types of the WAV header parser.
// No dependencies; imported by the divider, the top level and the testbench.
`default_nettype none

package whp_pkg;

  // Chunk ids, first stream byte in the top byte
  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT  = 32'h666D_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_BODY_LEN = 32'd16;

  // Divider operand widths: chunk size / ((bits/8) * channels)
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 29;

  // result_kind codes
  localparam logic RES_VERDICT = 1'b0;
  localparam logic RES_DATA    = 1'b1;

  // sample_kind codes
  localparam logic [1:0] KIND_INT8    = 2'd0;
  localparam logic [1:0] KIND_INT16   = 2'd1;
  localparam logic [1:0] KIND_FLOAT32 = 2'd2;

  localparam logic [15:0] BITS_INT8    = 16'd8;
  localparam logic [15:0] BITS_FLOAT32 = 16'd32;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

[hdl/whp_in_if.sv]
// Input channel: one file byte or an end-of-stream mark per transfer.
// Plain valid/ready handshake; no dependencies.
`default_nettype none

interface whp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte_in;
  logic       stream_end;

  modport source (output valid, output data_byte_in, output stream_end, input ready);
  modport sink   (input valid, input data_byte_in, input stream_end, output ready);
endinterface

`default_nettype wire

[hdl/whp_out_if.sv]
// Output channel: header verdict or audio byte per transfer.
// Plain valid/ready handshake; no dependencies.
`default_nettype none

interface whp_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        header_ok;
  logic [1:0]  sample_kind;
  logic [15:0] sample_bits;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [31:0] frame_count;
  logic [7:0]  audio_byte;
  logic        last_byte;

  modport source (output valid, output result_kind, output header_ok, output sample_kind,
                  output sample_bits, output channel_count, output sample_rate,
                  output frame_count, output audio_byte, output last_byte, input ready);
  modport sink   (input valid, input result_kind, input header_ok, input sample_kind,
                  input sample_bits, input channel_count, input sample_rate,
                  input frame_count, input audio_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[hdl/whp_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on whp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module whp_divider (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [whp_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic [whp_pkg::DIVISOR_W-1:0]  divisor,
  output whp_pkg::div_status_t                status,
  output logic      [whp_pkg::DIVIDEND_W-1:0] quotient,
  output logic      [whp_pkg::DIVISOR_W-1:0]  remainder
);
  import whp_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  divisor_q;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  ge;
  logic [DIVISOR_W-1:0]  rem_nx;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    rem_sh = {remainder, quotient[DIVIDEND_W-1]};
    ge     = (rem_sh >= {1'b0, divisor_q});
    if (ge) begin
      rem_nx = DIVISOR_W'(rem_sh - {1'b0, divisor_q});
    end else begin
      rem_nx = rem_sh[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      done      <= 1'b0;
      cnt       <= CNT_W'(DIVIDEND_W - 1);
      quotient  <= dividend;
      remainder <= '0;
      divisor_q <= divisor;
    end else if (busy) begin
      remainder <= rem_nx;
      quotient  <= {quotient[DIVIDEND_W-2:0], ge};
      cnt       <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

  `WHP_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "divider done while busy")
  `WHP_ASSERT_NXT(a_start_busy, clk, rst, start, busy, "divider did not start")
  `WHP_ASSERT_NXT(a_last_done, clk, rst, busy && cnt == '0 && !start, done,
                  "divider did not finish after last step")

endmodule

`default_nettype wire

[hdl/wav_header_parser.sv]
// WAV (RIFF/WAVE PCM) header parser, top level.
// Depends on whp_pkg, whp_in_if, whp_out_if, whp_divider and assert_macros.svh.
//
// Usage:
//   in_ch  carries the file one byte per transfer, little-endian as stored,
//          or a transfer with stream_end set that carries no byte.
//   out_ch carries one header verdict (result_kind 0) per file, then, after a
//          good verdict, the data chunk bytes of whole frames (result_kind 1),
//          the final one marked by last_byte.
// Throughput: one byte per cycle, while the output register is free, through the
//   RIFF header, chunk headers, fmt body, skipped chunks and the audio data. Once,
//   when the data chunk header completes, the frame count is computed by the
//   bit-serial divider, and in_ch.ready stays low until its quotient is taken.
// Output: a result is registered and shows on out_ch the cycle after the byte
//   that causes it; the good verdict instead follows the divider's completion.
// Stall: a single output register holds a pending result; while it is full and
//   out_ch.ready is low, in_ch.ready is low too. Nothing is dropped.
// Reset: rst (synchronous) returns to expecting the RIFF header; no clearing pass.
//   Once parsing ends (failed verdict, good verdict with no frames, last data byte
//   or stream end), all input is taken and ignored until reset.
`default_nettype none
`include "assert_macros.svh"

module wav_header_parser (
  input wire logic clk,
  input wire logic rst,
  whp_in_if.sink   in_ch,
  whp_out_if.source out_ch
);
  import whp_pkg::*;

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_RIFF_BAD,
    PH_FMT_HDR,
    PH_FMT_BODY,
    PH_FMT_EXTRA,
    PH_FMT_SKIP,
    PH_DATA_HDR,
    PH_DATA_SKIP,
    PH_DIV,
    PH_DATA_PASS,
    PH_DONE
  } phase_t;

  // little-endian byte insert; position 0 starts a fresh value
  function automatic logic [31:0] put_le(input logic [31:0] dst, input logic [7:0] b,
                                         input logic [1:0] pos);
    logic [31:0] r;
    r = dst;
    case (pos)
      2'd0:    r = {24'd0, b};
      2'd1:    r[15:8]  = b;
      2'd2:    r[23:16] = b;
      default: r[31:24] = b;
    endcase
    return r;
  endfunction

  // parse state
  phase_t      phase, phase_next;
  logic [4:0]  idx, idx_next;
  logic [31:0] id_shift, id_shift_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] skip_rem, skip_rem_next;
  logic [15:0] held_channels, held_channels_next;
  logic [31:0] held_rate, held_rate_next;
  logic [15:0] held_bits, held_bits_next;
  logic [31:0] held_frames, held_frames_next;
  logic [31:0] data_rem, data_rem_next;

  // output register
  logic        o_valid, o_valid_next;
  logic        o_kind, o_kind_next;
  logic        o_ok, o_ok_next;
  logic [1:0]  o_skind, o_skind_next;
  logic [15:0] o_bits, o_bits_next;
  logic [15:0] o_chan, o_chan_next;
  logic [31:0] o_rate, o_rate_next;
  logic [31:0] o_frames, o_frames_next;
  logic [7:0]  o_byte, o_byte_next;
  logic        o_last, o_last_next;

  logic                  out_free;
  logic                  accept;
  logic [7:0]            b;
  logic [31:0]           id_next;
  logic [31:0]           hdr_id;
  logic [31:0]           hdr_len;
  logic [31:0]           skip_dec;
  logic [31:0]           pass_dec;
  logic [DIVISOR_W-1:0]  bpf;
  logic                  bpf_zero;
  logic                  emit_fail, emit_good, emit_data;
  logic                  div_start;
  div_status_t           div_stat;
  logic [DIVIDEND_W-1:0] div_quot;
  logic [DIVISOR_W-1:0]  div_rem;

  assign out_free     = !o_valid || out_ch.ready;
  assign in_ch.ready  = (phase != PH_DIV) && out_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign b            = in_ch.data_byte_in;
  assign id_next      = {id_shift[23:0], b};

  // chunk header view including the byte now arriving
  assign hdr_id  = (idx < 5'd4) ? id_next : id_shift;
  assign hdr_len = (idx >= 5'd4) ? put_le(chunk_length, b, idx[1:0]) : chunk_length;

  assign skip_dec = (skip_rem != '0) ? skip_rem - 32'd1 : skip_rem;
  assign pass_dec = (data_rem != '0) ? data_rem - 32'd1 : data_rem;

  // bytes per frame; the divider registers this product at start
  assign bpf      = DIVISOR_W'(held_bits[15:3]) * DIVISOR_W'(held_channels);
  assign bpf_zero = (held_bits[15:3] == '0) || (held_channels == '0);

  whp_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (hdr_len),
    .divisor   (bpf),
    .status    (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_comb begin
    phase_next         = phase;
    idx_next           = idx;
    id_shift_next      = id_shift;
    chunk_length_next  = chunk_length;
    skip_rem_next      = skip_rem;
    held_channels_next = held_channels;
    held_rate_next     = held_rate;
    held_bits_next     = held_bits;
    held_frames_next   = held_frames;
    data_rem_next      = data_rem;
    emit_fail          = 1'b0;
    emit_good          = 1'b0;
    emit_data          = 1'b0;
    o_last_next        = 1'b0;
    div_start          = 1'b0;

    if (phase == PH_DIV) begin
      // frame count ready: emit verdict once the output register is free
      if (div_stat.done && out_free) begin
        held_frames_next = div_quot;
        data_rem_next    = chunk_length - 32'(div_rem);
        emit_good        = 1'b1;
        phase_next       = (data_rem_next != '0) ? PH_DATA_PASS : PH_DONE;
      end
    end else if (accept && phase != PH_DONE) begin
      if (in_ch.stream_end) begin
        phase_next = PH_DONE;
        emit_fail  = (phase != PH_DATA_PASS);
      end else begin
        unique case (phase)
          PH_RIFF, PH_RIFF_BAD: begin
            if (idx < 5'd4 || idx >= 5'd8) begin
              id_shift_next = id_next;
            end else begin
              chunk_length_next = put_le(chunk_length, b, idx[1:0]);
            end
            if (idx == 5'd3 && id_next != ID_RIFF) begin
              phase_next = PH_RIFF_BAD;
            end
            if (idx >= 5'd11) begin
              idx_next = '0;
              if (phase == PH_RIFF && id_next == ID_WAVE && chunk_length != '0) begin
                phase_next = PH_FMT_HDR;
              end else begin
                phase_next = PH_DONE;
                emit_fail  = 1'b1;
              end
            end else begin
              idx_next = idx + 5'd1;
            end
          end
          PH_FMT_HDR, PH_DATA_HDR: begin
            id_shift_next     = hdr_id;
            chunk_length_next = hdr_len;
            if (idx == 5'd7) begin
              idx_next = '0;
              if (phase == PH_FMT_HDR) begin
                if (hdr_id == ID_FMT && hdr_len >= FMT_BODY_LEN) begin
                  phase_next = PH_FMT_BODY;
                end else if (hdr_len == '0) begin
                  phase_next = PH_DONE;
                  emit_fail  = 1'b1;
                end else begin
                  skip_rem_next = hdr_len;
                  phase_next    = PH_FMT_SKIP;
                end
              end else if (!(hdr_id == ID_DATA && hdr_len != '0)) begin
                if (hdr_len == '0) begin
                  phase_next = PH_DONE;
                  emit_fail  = 1'b1;
                end else begin
                  skip_rem_next = hdr_len;
                  phase_next    = PH_DATA_SKIP;
                end
              end else if (bpf_zero) begin
                phase_next = PH_DONE;
                emit_fail  = 1'b1;
              end else begin
                div_start  = 1'b1;
                phase_next = PH_DIV;
              end
            end else begin
              idx_next = idx + 5'd1;
            end
          end
          PH_FMT_BODY: begin
            if (idx == 5'd2 || idx == 5'd3) begin
              held_channels_next = 16'(put_le({16'd0, held_channels}, b, {1'b0, idx[0]}));
            end else if (idx >= 5'd4 && idx < 5'd8) begin
              held_rate_next = put_le(held_rate, b, idx[1:0]);
            end else if (idx >= 5'd14) begin
              held_bits_next = 16'(put_le({16'd0, held_bits}, b, {1'b0, idx[0]}));
            end
            if (idx >= 5'd15) begin
              idx_next = '0;
              if (chunk_length > FMT_BODY_LEN) begin
                skip_rem_next = chunk_length - FMT_BODY_LEN;
                phase_next    = PH_FMT_EXTRA;
              end else begin
                phase_next = PH_DATA_HDR;
              end
            end else begin
              idx_next = idx + 5'd1;
            end
          end
          PH_FMT_EXTRA, PH_FMT_SKIP, PH_DATA_SKIP: begin
            skip_rem_next = skip_dec;
            if (skip_dec == '0) begin
              phase_next = (phase == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
            end
          end
          PH_DATA_PASS: begin
            emit_data     = 1'b1;
            data_rem_next = pass_dec;
            if (pass_dec == '0) begin
              o_last_next = 1'b1;
              phase_next  = PH_DONE;
            end
          end
          default: begin
            phase_next = PH_DONE;
          end
        endcase
      end
    end

    // output register load
    o_valid_next  = o_valid && !out_ch.ready;
    o_kind_next   = o_kind;
    o_ok_next     = o_ok;
    o_skind_next  = o_skind;
    o_bits_next   = o_bits;
    o_chan_next   = o_chan;
    o_rate_next   = o_rate;
    o_frames_next = o_frames;
    o_byte_next   = o_byte;
    if (emit_fail || emit_good || emit_data) begin
      o_valid_next  = 1'b1;
      o_kind_next   = emit_data ? RES_DATA : RES_VERDICT;
      o_ok_next     = emit_good;
      o_skind_next  = KIND_INT8;
      o_bits_next   = '0;
      o_chan_next   = '0;
      o_rate_next   = '0;
      o_frames_next = '0;
      o_byte_next   = emit_data ? b : 8'd0;
      if (emit_good) begin
        if (held_bits == BITS_INT8) begin
          o_skind_next = KIND_INT8;
        end else if (held_bits == BITS_FLOAT32) begin
          o_skind_next = KIND_FLOAT32;
        end else begin
          o_skind_next = KIND_INT16;
        end
        o_bits_next   = held_bits;
        o_chan_next   = held_channels;
        o_rate_next   = held_rate;
        o_frames_next = held_frames_next;
      end
    end else begin
      o_last_next = o_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_RIFF;
      idx           <= '0;
      id_shift      <= '0;
      chunk_length  <= '0;
      skip_rem      <= '0;
      held_channels <= '0;
      held_rate     <= '0;
      held_bits     <= '0;
      held_frames   <= '0;
      data_rem      <= '0;
      o_valid       <= 1'b0;
    end else begin
      phase         <= phase_next;
      idx           <= idx_next;
      id_shift      <= id_shift_next;
      chunk_length  <= chunk_length_next;
      skip_rem      <= skip_rem_next;
      held_channels <= held_channels_next;
      held_rate     <= held_rate_next;
      held_bits     <= held_bits_next;
      held_frames   <= held_frames_next;
      data_rem      <= data_rem_next;
      o_valid       <= o_valid_next;
    end
    o_kind   <= o_kind_next;
    o_ok     <= o_ok_next;
    o_skind  <= o_skind_next;
    o_bits   <= o_bits_next;
    o_chan   <= o_chan_next;
    o_rate   <= o_rate_next;
    o_frames <= o_frames_next;
    o_byte   <= o_byte_next;
    o_last   <= o_last_next;
  end

  assign out_ch.valid         = o_valid;
  assign out_ch.result_kind   = o_kind;
  assign out_ch.header_ok     = o_ok;
  assign out_ch.sample_kind   = o_skind;
  assign out_ch.sample_bits   = o_bits;
  assign out_ch.channel_count = o_chan;
  assign out_ch.sample_rate   = o_rate;
  assign out_ch.frame_count   = o_frames;
  assign out_ch.audio_byte    = o_byte;
  assign out_ch.last_byte     = o_last;

  `WHP_ASSERT_IMP(a_div_no_ready, clk, rst, phase == PH_DIV, !in_ch.ready,
                  "input taken during frame division")
  `WHP_ASSERT_IMP(a_div_in_phase, clk, rst, div_stat.busy, phase == PH_DIV,
                  "divider busy outside division phase")
  `WHP_ASSERT_IMP(a_pass_nonzero, clk, rst, phase == PH_DATA_PASS, data_rem != '0,
                  "data pass with no bytes remaining")
  `WHP_ASSERT_IMP(a_last_done, clk, rst,
                  o_valid && o_kind == RES_DATA && o_last, phase == PH_DONE,
                  "last data byte shown while still parsing")

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for wav_header_parser: builds one RIFF/WAVE byte stream of a
// randomly drawn shape, predicts every header verdict and audio byte, and checks them in order.
// Depends on whp_pkg, whp_in_if, whp_out_if and the parser RTL.

module testbench;
  import whp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int LONG_HOLD      = 120;   // one long receiver hold-off to back up the block
  localparam int DRAIN_CYCLES   = 40;    // settling margin after the drain, to catch stray results
  localparam int PRINT_CAP      = 40;
  localparam int DATA_TARGET    = 1300;  // audio bytes aimed for in a passing stream
  localparam int ITEM_TARGET    = 1700;  // input transfers per run, filler included

  // One input transfer: a file byte, or an end-of-stream mark.
  typedef struct packed {
    logic [7:0] octet;
    logic       eos;
  } stream_item_t;

  // One output transfer, field for field as on out_ch.
  typedef struct packed {
    logic        kind;
    logic        ok;
    logic [1:0]  skind;
    logic [15:0] nbits;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [31:0] frames;
    logic [7:0]  audio;
    logic        last;
  } wav_result_t;

  // Parser phases of the predictor.
  typedef enum logic [3:0] {
    P_RIFF, P_RIFF_BAD, P_FMT_HDR, P_FMT_BODY, P_FMT_EXTRA, P_FMT_SKIP,
    P_DATA_HDR, P_DATA_SKIP, P_DATA_PASS, P_DONE
  } parse_phase_e;

  // Shape of the one stream this run sends; reset happens only once, so a run
  // is one file, and the shape decides where (and whether) parsing fails.
  typedef enum int {
    SC_GOOD, SC_END_IN_DATA, SC_ZERO_FRAMES, SC_ZERO_DIVISOR, SC_FMT_SEARCH_SIZE0,
    SC_DATA_SEARCH_SIZE0, SC_END_IN_PARSE, SC_BAD_RIFF_ID, SC_BAD_FORM, SC_RIFF_SIZE0,
    SC_END_AT_START
  } file_shape_e;

  logic clk;
  logic rst;

  whp_in_if  in_ch();
  whp_out_if out_ch();

  wav_header_parser DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Queues and counters
  // ---------------------------------------------------------------------------
  stream_item_t wav_stream[$];        // file bytes still to be sent
  wav_result_t  predicted_results[$]; // results owed by the block, oldest first
  stream_item_t cur_item;

  file_shape_e shape;
  int pressure_at;
  bit pressure_done = 1'b0;
  int send_gap = 0, send_run = 0;
  int recv_stall = 0, recv_run = 0;
  int items_taken = 0, results_seen = 0, audio_seen = 0, error_count = 0;
  int idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor state, at reset values
  // ---------------------------------------------------------------------------
  parse_phase_e phase = P_RIFF;
  logic [31:0] fld_idx = '0;
  logic [31:0] id_word = '0;
  logic [31:0] chunk_len = '0;
  logic [31:0] skip_left = '0;
  logic [31:0] hold_chans = '0;
  logic [31:0] hold_rate = '0;
  logic [31:0] hold_bits = '0;
  logic [31:0] hold_frames = '0;
  logic [31:0] data_left = '0;

  // Little-endian field assembly; byte 0 restarts the field.
  function automatic logic [31:0] le_put(input logic [31:0] dst, input logic [7:0] b,
                                         input logic [31:0] pos);
    if (pos == 0) return {24'd0, b};
    return dst | ({24'd0, b} << (8 * pos[1:0]));
  endfunction

  // Gathers the 8-byte chunk header: id in stream order, then size LE.
  function automatic bit chunk_hdr_done(input logic [7:0] b);
    logic [31:0] idx;
    idx = fld_idx;
    if (idx < 4) id_word = {id_word[23:0], b};
    else chunk_len = le_put(chunk_len, b, idx - 4);
    if (idx >= 7) begin
      fld_idx = 0;
      return 1'b1;
    end
    fld_idx = idx + 1;
    return 1'b0;
  endfunction

  function automatic wav_result_t good_verdict();
    wav_result_t r;
    r = '0;
    r.kind = RES_VERDICT;
    r.ok = 1'b1;
    if (hold_bits == 32'(BITS_INT8)) r.skind = KIND_INT8;
    else if (hold_bits == 32'(BITS_FLOAT32)) r.skind = KIND_FLOAT32;
    else r.skind = KIND_INT16;
    r.nbits = hold_bits[15:0];
    r.chans = hold_chans[15:0];
    r.rate = hold_rate;
    r.frames = hold_frames;
    return r;
  endfunction

  // Advances the parser by one accepted transfer and queues what it owes.
  task automatic parse_wav_byte(input stream_item_t it);
    logic [31:0] idx, bpf;
    wav_result_t r;
    bit emit;
    idx = fld_idx;
    r = '0;
    r.kind = RES_VERDICT;   // an all-zero verdict is a failure verdict
    emit = 1'b0;
    if (phase == P_DONE) return;
    if (it.eos) begin
      // End of stream fails the header, but only quietly cuts off audio.
      emit = (phase != P_DATA_PASS);
      phase = P_DONE;
    end else begin
      case (phase)
        P_RIFF, P_RIFF_BAD: begin
          if (idx < 4 || idx >= 8) id_word = {id_word[23:0], it.octet};
          else chunk_len = le_put(chunk_len, it.octet, idx - 4);
          if (idx == 3 && id_word != ID_RIFF) phase = P_RIFF_BAD;
          if (idx >= 11) begin
            fld_idx = 0;
            if (phase == P_RIFF && id_word == ID_WAVE && chunk_len != 0) begin
              phase = P_FMT_HDR;
            end else begin
              phase = P_DONE;
              emit = 1'b1;
            end
          end else begin
            fld_idx = idx + 1;
          end
        end
        P_FMT_HDR: if (chunk_hdr_done(it.octet)) begin
          if (id_word == ID_FMT && chunk_len >= FMT_BODY_LEN) begin
            phase = P_FMT_BODY;
          end else if (chunk_len == 0) begin
            phase = P_DONE;
            emit = 1'b1;
          end else begin
            skip_left = chunk_len;
            phase = P_FMT_SKIP;
          end
        end
        P_FMT_BODY: begin
          if (idx >= 2 && idx < 4) hold_chans = le_put(hold_chans, it.octet, idx - 2);
          else if (idx >= 4 && idx < 8) hold_rate = le_put(hold_rate, it.octet, idx - 4);
          else if (idx >= 14) hold_bits = le_put(hold_bits, it.octet, idx - 14);
          if (idx >= 15) begin
            fld_idx = 0;
            if (chunk_len > FMT_BODY_LEN) begin
              skip_left = chunk_len - FMT_BODY_LEN;
              phase = P_FMT_EXTRA;
            end else begin
              phase = P_DATA_HDR;
            end
          end else begin
            fld_idx = idx + 1;
          end
        end
        P_FMT_EXTRA, P_FMT_SKIP, P_DATA_SKIP: begin
          if (skip_left > 0) skip_left--;
          if (skip_left == 0) phase = (phase == P_FMT_SKIP) ? P_FMT_HDR : P_DATA_HDR;
        end
        P_DATA_HDR: if (chunk_hdr_done(it.octet)) begin
          if (id_word != ID_DATA || chunk_len == 0) begin
            if (chunk_len == 0) begin
              phase = P_DONE;
              emit = 1'b1;
            end else begin
              skip_left = chunk_len;
              phase = P_DATA_SKIP;
            end
          end else begin
            bpf = (hold_bits / 8) * hold_chans;
            if (bpf == 0) begin
              phase = P_DONE;
              emit = 1'b1;
            end else begin
              hold_frames = chunk_len / bpf;
              data_left = hold_frames * bpf;
              phase = (data_left != 0) ? P_DATA_PASS : P_DONE;
              r = good_verdict();
              emit = 1'b1;
            end
          end
        end
        P_DATA_PASS: begin
          r.kind = RES_DATA;
          r.audio = it.octet;
          if (data_left > 0) data_left--;
          if (data_left == 0) begin
            r.last = 1'b1;
            phase = P_DONE;
          end
          emit = 1'b1;
        end
        default: phase = P_DONE;
      endcase
    end
    if (emit) predicted_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("[%0t] result %0d: %s: got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
  endtask

  task automatic check_result(input wav_result_t got);
    wav_result_t want;
    if (predicted_results.size() == 0) begin
      report_mismatch("result with nothing expected", 32'(got.kind), 32'd0);
      return;
    end
    want = predicted_results.pop_front();
    if (got.kind !== want.kind)
      report_mismatch("result_kind", 32'(got.kind), 32'(want.kind));
    if (got.ok !== want.ok)
      report_mismatch("header_ok", 32'(got.ok), 32'(want.ok));
    if (got.skind !== want.skind)
      report_mismatch("sample_kind", 32'(got.skind), 32'(want.skind));
    if (got.nbits !== want.nbits)
      report_mismatch("sample_bits", 32'(got.nbits), 32'(want.nbits));
    if (got.chans !== want.chans)
      report_mismatch("channel_count", 32'(got.chans), 32'(want.chans));
    if (got.rate !== want.rate) report_mismatch("sample_rate", got.rate, want.rate);
    if (got.frames !== want.frames) report_mismatch("frame_count", got.frames, want.frames);
    if (got.audio !== want.audio)
      report_mismatch("audio_byte", 32'(got.audio), 32'(want.audio));
    if (got.last !== want.last)
      report_mismatch("last_byte", 32'(got.last), 32'(want.last));
  endtask

  // Per-item random wait, with occasional runs of back-to-back items.
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      run_left = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  // ---------------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------------
  task automatic put_octet(input logic [7:0] b);
    stream_item_t it;
    it.octet = b;
    it.eos = 1'b0;
    wav_stream.push_back(it);
  endtask

  // End mark; the byte lane carries junk that must be ignored.
  task automatic put_end();
    stream_item_t it;
    it.octet = 8'($urandom);
    it.eos = 1'b1;
    wav_stream.push_back(it);
  endtask

  task automatic put_u16(input logic [15:0] v);
    put_octet(v[7:0]);
    put_octet(v[15:8]);
  endtask

  task automatic put_u32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) put_octet(v[8*i +: 8]);
  endtask

  // Chunk ids go out first character first.
  task automatic put_id(input logic [31:0] id);
    for (int i = 3; i >= 0; i--) put_octet(id[8*i +: 8]);
  endtask

  task automatic put_noise(input int n);
    repeat (n) put_octet(8'($urandom));
  endtask

  // Chunks the parser must skip: foreign ids, decoy ids, short "fmt ",
  // odd sizes and now and then a longer body.
  task automatic put_junk(input bit fmt_search, input int budget);
    int start, pick;
    logic [31:0] id, size;
    start = wav_stream.size();
    while (wav_stream.size() - start < budget) begin
      pick = $urandom_range(0, 9);
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
      case (pick)
        0: id = fmt_search ? ID_DATA : ID_FMT;
        1: begin
          id = ID_FMT;
          if (fmt_search) size = $urandom_range(1, 15);  // too short to be the format
        end
        2: id = ID_RIFF;
        3: id = ID_WAVE;
        default: id = $urandom;
      endcase
      put_id(id);
      put_u32(size);
      put_noise(size);
    end
  endtask

  task automatic put_fmt(input logic [15:0] chans, input logic [15:0] nbits);
    int extra;
    logic [31:0] rate;
    extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 24) : 0;
    case ($urandom_range(0, 4))
      0: rate = 32'd44100;
      1: rate = 32'd48000;
      2: rate = 32'd0;
      3: rate = 32'hFFFF_FFFF;
      default: rate = $urandom;
    endcase
    put_id(ID_FMT);
    put_u32(FMT_BODY_LEN + extra);
    put_u16(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd1);  // format tag, not checked
    put_u16(chans);
    put_u32(rate);
    put_u32($urandom);                                     // byte rate
    put_u16(16'($urandom));                                // block align
    put_u16(nbits);
    put_noise(extra);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and the stimulus/end-of-run sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int pick, spot, fmt_junk, data_junk;
    logic [15:0] chans, nbits;
    logic [31:0] bpf, size;

    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte_in = 8'd0;
    in_ch.stream_end = 1'b0;
    out_ch.ready = 1'b0;

    pick = $urandom_range(0, 99);
    if (pick < 35) shape = SC_GOOD;
    else if (pick < 50) shape = SC_END_IN_DATA;
    else if (pick < 58) shape = SC_ZERO_FRAMES;
    else if (pick < 66) shape = SC_ZERO_DIVISOR;
    else if (pick < 73) shape = SC_FMT_SEARCH_SIZE0;
    else if (pick < 80) shape = SC_DATA_SEARCH_SIZE0;
    else if (pick < 90) shape = SC_END_IN_PARSE;
    else if (pick < 93) shape = SC_BAD_RIFF_ID;
    else if (pick < 96) shape = SC_BAD_FORM;
    else if (pick < 98) shape = SC_RIFF_SIZE0;
    else shape = SC_END_AT_START;

    // Format defaults: common widths, a few channels.
    chans = 16'($urandom_range(1, 6));
    case ($urandom_range(0, 4))
      0: nbits = 16'd8;
      1: nbits = 16'd16;
      2: nbits = 16'd24;
      3: nbits = 16'd32;
      default: nbits = 16'($urandom_range(8, 64));
    endcase
    case (shape)
      SC_ZERO_FRAMES: begin
        // Widest frames: data chunk smaller than one frame.
        if ($urandom_range(0, 1)) begin
          chans = 16'hFFFF;
          nbits = 16'($urandom_range(8, 16'hFFFF));
        end else begin
          chans = 16'($urandom_range(1, 16'hFFFF));
          nbits = 16'hFFFF;
        end
      end
      SC_ZERO_DIVISOR: begin
        if ($urandom_range(0, 1)) begin
          nbits = 16'($urandom_range(0, 7));
          chans = 16'($urandom_range(0, 16'hFFFF));
        end else begin
          chans = 16'd0;
          nbits = 16'($urandom_range(0, 16'hFFFF));
        end
      end
      SC_END_IN_DATA: if ($urandom_range(0, 1)) begin
        chans = 16'd1;
        nbits = 16'd8;
      end
      default: ;
    endcase
    bpf = 32'(nbits / 16'd8) * 32'(chans);

    // Streams that fail late carry a lot of skipped chunks first.
    fmt_junk = $urandom_range(0, 150);
    data_junk = $urandom_range(0, 150);
    if (shape inside {SC_ZERO_FRAMES, SC_ZERO_DIVISOR, SC_DATA_SEARCH_SIZE0, SC_END_IN_PARSE}) begin
      fmt_junk = 700;
      data_junk = 800;
    end else if (shape == SC_FMT_SEARCH_SIZE0) begin
      fmt_junk = 1500;
    end
    pressure_at = (shape inside {SC_GOOD, SC_END_IN_DATA}) ? $urandom_range(1, 40) : 0;
    spot = $urandom_range(0, 2);

    if (shape == SC_END_AT_START) begin
      put_end();
      put_noise(30);
    end else begin
      put_id((shape == SC_BAD_RIFF_ID) ? ID_RIFF ^ (32'd1 << $urandom_range(0, 31)) : ID_RIFF);
      if (shape == SC_RIFF_SIZE0) put_u32(32'd0);
      else put_u32(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'd1));
      put_id((shape == SC_BAD_FORM) ? ID_WAVE ^ (32'd1 << $urandom_range(0, 31)) : ID_WAVE);

      if (shape inside {SC_BAD_RIFF_ID, SC_BAD_FORM, SC_RIFF_SIZE0}) begin
        put_noise(30);
      end else begin
        put_junk(1'b1, fmt_junk);
        if (shape == SC_FMT_SEARCH_SIZE0) begin
          case ($urandom_range(0, 2))
            0: put_id(ID_FMT);
            1: put_id(ID_DATA);
            default: put_id($urandom);
          endcase
          put_u32(32'd0);
          put_noise(20);
        end else if (shape == SC_END_IN_PARSE && spot == 0) begin
          // ends inside a chunk header or a skipped body
          put_noise($urandom_range(0, 20));
          put_end();
          put_noise(10);
        end else if (shape == SC_END_IN_PARSE && spot == 1) begin
          // ends inside the format body
          put_id(ID_FMT);
          put_u32(FMT_BODY_LEN);
          put_noise($urandom_range(0, 15));
          put_end();
          put_noise(10);
        end else begin
          put_fmt(chans, nbits);
          put_junk(1'b0, data_junk);
          case (shape)
            SC_DATA_SEARCH_SIZE0: begin
              put_id($urandom_range(0, 1) ? ID_DATA : $urandom);
              put_u32(32'd0);
              put_noise(20);
            end
            SC_END_IN_PARSE: begin
              put_noise($urandom_range(0, 20));
              put_end();
              put_noise(10);
            end
            SC_ZERO_DIVISOR: begin
              put_id(ID_DATA);
              put_u32($urandom | 32'd1);
              put_noise(20);
            end
            SC_ZERO_FRAMES: begin
              put_id(ID_DATA);
              put_u32($urandom_range(1, bpf - 1));
              put_noise(20);
            end
            SC_END_IN_DATA: begin
              // data chunk far longer than the stream; end cuts the audio off
              size = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h0010_0000);
              put_id(ID_DATA);
              put_u32(size);
              put_noise(DATA_TARGET);
              put_end();
              put_noise(10);
            end
            default: begin
              // whole frames plus a partial one that must be dropped
              size = (DATA_TARGET / bpf) * bpf + $urandom_range(0, bpf - 1);
              put_id(ID_DATA);
              put_u32(size);
              put_noise(size);
              put_noise(10);
              put_end();
              put_noise(5);
            end
          endcase
        end
      end
    end

    // Every shape has ended or failed by now; filler bytes are taken and ignored.
    if (wav_stream.size() < ITEM_TARGET) put_noise(ITEM_TARGET - wav_stream.size());

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent, everything owed delivered, then a settling margin.
    while (wav_stream.size() != 0 || in_ch.valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_results.size() != 0)
      report_mismatch("results never delivered", predicted_results.size(), 0);

    $display("Run covered a %s stream: %0d input transfers, %0d results, %0d audio bytes.",
             shape.name(), items_taken, results_seen, audio_seen);
    $display("Mismatches: %0d", error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: one item per transfer, random gap before each new item.
  // Prediction runs on the item at the edge it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parse_wav_byte(cur_item);
        items_taken++;
      end
      // Slot is free when nothing is offered or the offer was just taken.
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (wav_stream.size() > 0) begin
          cur_item = wav_stream.pop_front();
          in_ch.data_byte_in <= cur_item.octet;
          in_ch.stream_end <= cur_item.eos;
          in_ch.valid <= 1'b1;
          send_gap = draw_wait(send_run);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor/receiver: checks each transfer, then stalls for a random wait. Once,
  // with a result waiting, ready is held low for a long hold (LONG_HOLD) so the
  // output register fills and in_ch.ready has to drop.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    wav_result_t got;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind = out_ch.result_kind;
        got.ok = out_ch.header_ok;
        got.skind = out_ch.sample_kind;
        got.nbits = out_ch.sample_bits;
        got.chans = out_ch.channel_count;
        got.rate = out_ch.sample_rate;
        got.frames = out_ch.frame_count;
        got.audio = out_ch.audio_byte;
        got.last = out_ch.last_byte;
        check_result(got);
        results_seen++;
        if (got.kind == RES_DATA) audio_seen++;
        recv_stall = draw_wait(recv_run);
      end
      if (!pressure_done && out_ch.valid && results_seen >= pressure_at) begin
        pressure_done = 1'b1;
        recv_stall = LONG_HOLD;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any transfer on either side counts as progress.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, predicted_results.size());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
